FILE: src/fptw_pkg.sv
// shared types, constants and helpers for the four-level page table walker
// no dependencies

package fptw_pkg;

  localparam int STORE_WORDS_DEF = 4096;
  localparam int TABLE_WORDS     = 512;
  localparam int IDX_W           = 9;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_XLATE = 2'd1;
  localparam logic [1:0] CMD_UNMAP = 2'd2;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_ROOT_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOT_PRESENT   = 3'd2;
  localparam logic [2:0] ST_LARGE_REFUSED = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd4;

  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_1G   = 2'd1;
  localparam logic [1:0] LVL_2M   = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // 9-bit table index of a virtual address at a given walk level
  function automatic logic [IDX_W-1:0] idx_of(input logic [47:0] va, input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    unique case (lvl)
      LVL_TOP: r = va[47:39];
      LVL_1G:  r = va[38:30];
      LVL_2M:  r = va[29:21];
      LVL_LEAF: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

FILE: src/four_level_page_table_walker.sv
// top level of the four-level page table walker: command decode, walk sequencer, result register
// depends on fptw_pkg and fptw_store

// After reset the block zeroes its table store, one word per cycle, and holds in_ready
// low meanwhile. Then it takes one command at a time. A table write, an unused
// command, a zero root or a root table outside the store passes through the S_FIN
// state to the output register. A translate or unmap reads one store word per level
// on the store's single read port, visiting one to four levels; an unmap clears its
// leaf in the cycle its result moves into the output register. The result sits in an
// output register; a new command is taken while it waits, and the walk (or S_FIN)
// holds until the register is free.

module four_level_page_table_walker #(
  parameter int STORE_WORDS = fptw_pkg::STORE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [51:0] root_base,
  input  logic [47:0] virt_addr,
  input  logic [11:0] word_index,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [51:0] phys_addr,
  output logic [1:0]  pg_size,
  output logic [1:0]  fault_level
);
  import fptw_pkg::*;

  localparam int AW     = $clog2(STORE_WORDS);
  localparam int TABLES = STORE_WORDS / TABLE_WORDS;

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic [1:0]    lvl;
  logic          unmap_r;
  logic [47:0]   va_r;
  logic [AW-1:0] cur_addr;
  logic [2:0]    fin_status;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        is_walk_cmd;
  logic        root_ok;
  logic        walking;
  logic        next_ok;
  logic [1:0]  lvl_next;
  logic        w_done;
  logic        w_clear;
  logic [2:0]  w_status;
  logic [51:0] w_phys;
  logic [1:0]  w_size;
  logic [1:0]  w_level;

  fptw_store #(.WORDS(STORE_WORDS)) u_store (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  always_comb begin
    in_ready    = (state == S_IDLE);
    accept      = in_valid && in_ready;
    out_free    = !out_valid || out_ready;
    out_load    = out_free && ((state == S_WALK && w_done) || state == S_FIN);
    is_walk_cmd = (cmd == CMD_XLATE) || (cmd == CMD_UNMAP);
    root_ok     = root_base[51:12] < 40'(TABLES);
    walking     = is_walk_cmd && (root_base != 52'd0) && root_ok;
    next_ok     = rd_data[51:12] < 40'(TABLES);
    lvl_next    = lvl + 2'd1;
  end

  // decision on the entry just read
  always_comb begin
    w_done   = 1'b1;
    w_clear  = 1'b0;
    w_status = ST_OK;
    w_phys   = 52'd0;
    w_size   = SIZE_4K;
    w_level  = lvl;
    priority if (!rd_data[BIT_PRESENT]) begin
      w_status = ST_NOT_PRESENT;
    end else if (lvl == LVL_LEAF) begin
      if (unmap_r) begin
        w_clear = 1'b1;
        w_phys  = {rd_data[51:12], 12'd0};
      end else begin
        w_phys  = {rd_data[51:12], va_r[11:0]};
      end
    end else if (lvl != LVL_TOP && rd_data[BIT_LARGE]) begin
      w_size = (lvl == LVL_1G) ? SIZE_1G : SIZE_2M;
      if (unmap_r) begin
        w_status = ST_LARGE_REFUSED;
      end else if (lvl == LVL_1G) begin
        w_phys = {rd_data[51:30], va_r[29:0]};
      end else begin
        w_phys = {rd_data[51:21], va_r[20:0]};
      end
    end else if (!next_ok) begin
      w_status = ST_OUT_OF_RANGE;
      w_level  = lvl_next;
    end else begin
      w_done = 1'b0;
    end
  end

  // store port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cur_addr;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = 64'd0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_IDLE: begin
        mem_raddr = AW'({root_base[51:12], idx_of(virt_addr, LVL_TOP)});
        mem_re    = accept && walking;
        if (accept && cmd == CMD_WRITE && 32'(word_index) < STORE_WORDS) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(word_index);
          mem_wdata = write_data;
        end
      end
      S_WALK: begin
        mem_raddr = AW'({rd_data[51:12], idx_of(va_r, lvl_next)});
        mem_re    = !w_done;
        // unmap clears the leaf in the cycle its result transfers to the output register
        mem_we    = w_done && w_clear && out_free;
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      lvl       <= LVL_TOP;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(STORE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            lvl   <= LVL_TOP;
            state <= walking ? S_WALK : S_FIN;
          end
        end
        S_WALK: begin
          if (!w_done) begin
            lvl <= lvl_next;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      va_r     <= virt_addr;
      unmap_r  <= (cmd == CMD_UNMAP);
      cur_addr <= mem_raddr;
      if (!is_walk_cmd) begin
        fin_status <= ST_OK;
      end else if (root_base == 52'd0) begin
        fin_status <= ST_ROOT_ZERO;
      end else begin
        fin_status <= ST_OUT_OF_RANGE;
      end
    end else if (state == S_WALK && !w_done) begin
      cur_addr <= mem_raddr;
    end
    if (state == S_WALK && w_done && out_free) begin
      status      <= w_status;
      phys_addr   <= w_phys;
      pg_size     <= w_size;
      fault_level <= w_level;
    end else if (state == S_FIN && out_free) begin
      status      <= fin_status;
      phys_addr   <= 52'd0;
      pg_size     <= SIZE_4K;
      fault_level <= LVL_TOP;
    end
  end

`ifndef SYNTHESIS
  // store writes during a walk are only the unmap clear of a 4 KiB leaf
  a_walk_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && mem_we) |-> (unmap_r && lvl == LVL_LEAF && mem_wdata == 64'd0))
    else $error("walk wrote the store outside an unmap leaf clear");

  // a result only appears from the end of a walk or a short command
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_WALK || $past(state) == S_FIN))
    else $error("result appeared without a finishing state");

  // every input transfer starts a walk at the top level or a short result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_WALK && lvl == LVL_TOP) || state == S_FIN))
    else $error("bad state after input transfer");

  // no input is taken while the store is being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!in_ready && !mem_re))
    else $error("activity during clearing pass");
`endif

endmodule

FILE: src/fptw_store.sv
// table store: one write port, one read port with registered read data
// depends on fptw_pkg for the default depth

module fptw_store #(
  parameter int WORDS = fptw_pkg::STORE_WORDS_DEF,
  localparam int AW = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);
  import fptw_pkg::*;

  logic [63:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: bench/tb_four_level_page_table_walker.sv
// self-checking testbench for four_level_page_table_walker: a directed table of walks, then
// random map / translate / unmap sequences, checked against typed results or an in-bench walk predictor
// depends on fptw_pkg and the walker rtl

module tb_four_level_page_table_walker;
  import fptw_pkg::*;

  localparam int          NUM_TABLES     = STORE_WORDS_DEF / TABLE_WORDS;
  localparam int          TBL_W          = $clog2(NUM_TABLES);
  localparam int          RANDOM_ITEMS   = 2000;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          NUM_SLOTS      = 8;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  // nonzero root whose address bits are zero: root table sits at word 0
  localparam logic [51:0] ROOT_T0        = 52'h0_0000_0000_0FFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] pa;
    logic [1:0]  size;
    logic [1:0]  lvl;
  } xlat_res_t;

  typedef struct packed {
    logic [1:0]  c;
    logic [51:0] root;
    logic [47:0] va;
    logic [11:0] widx;
    logic [63:0] data;
    bit          typed;
    xlat_res_t   res;
  } dir_row_t;

  localparam xlat_res_t WRITE_DONE = '{ST_OK, 52'd0, SIZE_4K, LVL_TOP};

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [51:0] root_base;
  logic [47:0] virt_addr;
  logic [11:0] word_index;
  logic [63:0] write_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [51:0] phys_addr;
  logic [1:0]  pg_size;
  logic [1:0]  fault_level;

  logic [63:0] table_image [STORE_WORDS_DEF];
  xlat_res_t   pending_results [$];
  dir_row_t    directed_rows [$];
  xlat_res_t   want_res;
  int          err_count   = 0;
  int          idle_cycles = 0;
  int          sent_count  = 0;
  bit          no_idle     = 1'b0;
  logic [47:0] slot_va [NUM_SLOTS];
  logic [TBL_W-1:0] slot_tbl [NUM_SLOTS][4];

  always #5 clk = ~clk;

  four_level_page_table_walker u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .root_base   (root_base),
    .virt_addr   (virt_addr),
    .word_index  (word_index),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .phys_addr   (phys_addr),
    .pg_size     (pg_size),
    .fault_level (fault_level)
  );

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // walks the bench copy of the table store, updating it for writes and unmaps
  function automatic xlat_res_t expected_translation(input logic [1:0] c,
      input logic [51:0] root, input logic [47:0] va, input logic [11:0] widx,
      input logic [63:0] data);
    xlat_res_t   r;
    logic [51:0] tbl;
    logic [63:0] ent;
    logic [8:0]  ix;
    int          wa;
    r = WRITE_DONE;
    if (c == CMD_WRITE) begin
      table_image[widx] = data;
      return r;
    end
    if (c == CMD_UNUSED) return r;
    if (root == 52'd0) begin
      r.status = ST_ROOT_ZERO;
      return r;
    end
    tbl = {root[51:12], 12'd0};
    for (int lv = 0; lv < 4; lv++) begin
      r.lvl = 2'(lv);
      ix    = 9'(va >> (39 - 9 * lv));
      // the whole 512-word table has to fit in the store
      if (tbl[51:12] >= 40'(NUM_TABLES)) begin
        r.status = ST_OUT_OF_RANGE;
        return r;
      end
      wa  = int'(tbl[31:12]) * TABLE_WORDS + int'(ix);
      ent = table_image[wa];
      if (!ent[BIT_PRESENT]) begin
        r.status = ST_NOT_PRESENT;
        return r;
      end
      if (lv == 3) begin
        if (c == CMD_UNMAP) begin
          r.pa = {ent[51:12], 12'd0};
          table_image[wa] = 64'd0;
        end else begin
          r.pa = {ent[51:12], va[11:0]};
        end
        return r;
      end
      // large bit only counts below the top level
      if (lv >= 1 && ent[BIT_LARGE]) begin
        r.size = (lv == 1) ? SIZE_1G : SIZE_2M;
        if (c == CMD_UNMAP) r.status = ST_LARGE_REFUSED;
        else if (lv == 1) r.pa = {ent[51:30], va[29:0]};
        else r.pa = {ent[51:21], va[20:0]};
        return r;
      end
      tbl = {ent[51:12], 12'd0};
    end
    return r;
  endfunction

  task automatic issue_command(input logic [1:0] c, input logic [51:0] root,
      input logic [47:0] va, input logic [11:0] widx, input logic [63:0] data,
      input bit typed, input xlat_res_t typed_res);
    int        gap;
    xlat_res_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    root_base  <= root;
    virt_addr  <= va;
    word_index <= widx;
    write_data <= data;
    do @(posedge clk); while (!in_ready);
    pred = expected_translation(c, root, va, widx, data);
    pending_results.push_back(typed ? typed_res : pred);
    sent_count++;
  endtask

  function automatic void add_row(input logic [1:0] c, input logic [51:0] root,
      input logic [47:0] va, input logic [11:0] widx, input logic [63:0] data,
      input bit typed, input xlat_res_t res);
    directed_rows.push_back('{c, root, va, widx, data, typed, res});
  endfunction

  function automatic void refresh_slot(input int s);
    slot_va[s] = 48'({$urandom, $urandom});
    for (int lv = 0; lv < 4; lv++) slot_tbl[s][lv] = TBL_W'($urandom_range(0, NUM_TABLES - 1));
  endfunction

  // writes the path of a slot from a random level down to its leaf
  task automatic map_slot(input int s);
    logic [63:0] ent;
    logic [8:0]  ix;
    int          first_lvl;
    first_lvl = $urandom_range(0, 3);
    for (int lv = first_lvl; lv < 4; lv++) begin
      ix  = 9'(slot_va[s] >> (39 - 9 * lv));
      ent = {$urandom, $urandom};
      ent[BIT_PRESENT] = ($urandom_range(0, 19) != 0);
      if (lv == 1 || lv == 2) ent[BIT_LARGE] = ($urandom_range(0, 4) == 0);
      // link to the next table, now and then leave a stray address
      if (lv < 3 && !(lv > 0 && ent[BIT_LARGE]) && $urandom_range(0, 19) != 0)
        ent[51:12] = 40'(slot_tbl[s][lv + 1]);
      issue_command(CMD_WRITE, 52'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                    12'(slot_tbl[s][lv] * TABLE_WORDS + ix), ent, 1'b0, '0);
    end
  endtask

  task automatic access_slot(input int s);
    logic [47:0] va;
    logic [51:0] root;
    va       = slot_va[s];
    va[11:0] = 12'($urandom);
    root     = (52'(slot_tbl[s][0]) << 12) | 52'($urandom_range(0, 4095));
    issue_command(($urandom_range(0, 2) == 0) ? CMD_UNMAP : CMD_XLATE, root, va,
                  12'($urandom), 64'({$urandom, $urandom}), 1'b0, '0);
  endtask

  task automatic wild_access();
    logic [51:0] root;
    case ($urandom_range(0, 3))
      0: root = 52'd0;
      1: root = 52'({$urandom, $urandom});
      default: root = (52'($urandom_range(0, NUM_TABLES)) << 12) | 52'($urandom_range(0, 4095));
    endcase
    issue_command(2'($urandom), root, 48'({$urandom, $urandom}), 12'($urandom),
                  64'({$urandom, $urandom}), 1'b0, '0);
  endtask

  initial begin
    int s;
    int pick;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_WRITE;
    root_base  = 52'd0;
    virt_addr  = 48'd0;
    word_index = 12'd0;
    write_data = 64'd0;
    foreach (table_image[i]) table_image[i] = 64'd0;
    for (int i = 0; i < NUM_SLOTS; i++) refresh_slot(i);

    add_row(CMD_XLATE, 52'h0, 48'hFFFF_FFFF_FFFF, 12'h000, 64'h0, 1'b1,
            '{ST_ROOT_ZERO, 52'h0, SIZE_4K, LVL_TOP});
    add_row(CMD_UNMAP, 52'h0_0000_0000_8000, 48'h0, 12'h000, 64'h0, 1'b1,
            '{ST_OUT_OF_RANGE, 52'h0, SIZE_4K, LVL_TOP});
    add_row(CMD_XLATE, 52'hF_FFFF_FFFF_FFFF, 48'h0, 12'h000, 64'h0, 1'b1,
            '{ST_OUT_OF_RANGE, 52'h0, SIZE_4K, LVL_TOP});
    add_row(CMD_XLATE, ROOT_T0, 48'h0, 12'h000, 64'h0, 1'b1,
            '{ST_NOT_PRESENT, 52'h0, SIZE_4K, LVL_TOP});
    add_row(CMD_UNUSED, ROOT_T0, 48'hFFFF_FFFF_FFFF, 12'h000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            WRITE_DONE);
    // top entry with large bit, which the walk ignores
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h000, 64'h0000_0000_0000_1081, 1'b1, WRITE_DONE);
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h201, 64'hFFFF_FFFF_C000_0081, 1'b1, WRITE_DONE);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_7FFF_FFFF, 12'h000, 64'h0, 1'b1,
            '{ST_OK, 52'hF_FFFF_FFFF_FFFF, SIZE_1G, LVL_1G});
    add_row(CMD_UNMAP, ROOT_T0, 48'h0000_7FFF_FFFF, 12'h000, 64'h0, 1'b1,
            '{ST_LARGE_REFUSED, 52'h0, SIZE_1G, LVL_1G});
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h200, 64'h0000_0000_0000_2003, 1'b1, WRITE_DONE);
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h400, 64'h8000_0000_0020_0081, 1'b1, WRITE_DONE);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_001F_FFFF, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_UNMAP, ROOT_T0, 48'h0, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h401, 64'h0000_0000_0000_3001, 1'b1, WRITE_DONE);
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, WRITE_DONE);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_003F_FFFF, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_UNMAP, ROOT_T0, 48'h0000_003F_F000, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_003F_FFFF, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_8000_0000, 12'h000, 64'h0, 1'b0, '0);
    // level-1 entry pointing just past the store
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'h203, 64'h0000_0000_0000_8001, 1'b1, WRITE_DONE);
    add_row(CMD_XLATE, ROOT_T0, 48'h0000_C000_0000, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_XLATE, ROOT_T0, 48'hFFFF_FFFF_FFFF, 12'h000, 64'h0, 1'b0, '0);
    add_row(CMD_WRITE, ROOT_T0, 48'h0, 12'hFFF, 64'h0, 1'b1, WRITE_DONE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_command(directed_rows[i].c, directed_rows[i].root, directed_rows[i].va,
                    directed_rows[i].widx, directed_rows[i].data, directed_rows[i].typed,
                    directed_rows[i].res);

    while (sent_count < directed_rows.size() + RANDOM_ITEMS) begin
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      s    = $urandom_range(0, NUM_SLOTS - 1);
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        if ($urandom_range(0, 9) == 0) refresh_slot(s);
        map_slot(s);
        repeat ($urandom_range(1, 3)) access_slot(s);
      end else if (pick < 14) begin
        access_slot(s);
      end else if (pick < 17) begin
        issue_command(CMD_WRITE, 52'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      12'($urandom), 64'({$urandom, $urandom}), 1'b0, '0);
      end else begin
        wild_access();
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // result side: random stall before each transfer
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        want_res = pending_results.pop_front();
        if (status !== want_res.status)
          flag_mismatch($sformatf("status got %0d want %0d", status, want_res.status));
        if (phys_addr !== want_res.pa)
          flag_mismatch($sformatf("phys_addr got %h want %h", phys_addr, want_res.pa));
        if (pg_size !== want_res.size)
          flag_mismatch($sformatf("pg_size got %0d want %0d", pg_size, want_res.size));
        if (fault_level !== want_res.lvl)
          flag_mismatch($sformatf("fault_level got %0d want %0d", fault_level, want_res.lvl));
      end
    end
  end

  // covers the store clear after reset with plenty of margin
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
